/* rtl/utf8_to_ucs2_decoder_core_macros.svh */
// assertion helpers for the decoder
`ifndef UTF8_TO_UCS2_DECODER_CORE_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define U8U2_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define U8U2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/u8u2_pkg.sv */
package u8u2_pkg;

  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [15:0] MAX_CHARS_RST = 16'd256;

  localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
  localparam logic [7:0] CONT_CODE  = 8'b1000_0000;
  localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
  localparam logic [7:0] LEAD2_CODE = 8'b1100_0000;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_CODE = 8'b1110_0000;
  localparam logic [7:0] CONT_BITS  = 8'b0011_1111;
  localparam logic [7:0] LEAD2_BITS = 8'b0001_1111;
  localparam logic [7:0] LEAD3_BITS = 8'b0000_1111;

  localparam logic [2:0] REG_MAX_CHARS = 3'd0;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0]        pending;
    logic [UNIT_W-1:0] partial;
    logic [15:0]       units;
    logic              skipping;
  } dec_state_t;

endpackage

/* rtl/utf8_to_ucs2_decoder_core.sv */
// UTF-8 to 16-bit code unit decoder, Basic Multilingual Plane only. One byte enters per beat on
// the s_ side; each complete one-, two- or three-byte sequence leaves as one 16-bit unit on the
// m_ side. A zero byte ends the string with a zero unit marked by m_tlast. Once max_chars units
// of a string have gone out, a zero unit with m_tlast follows straight away and the bytes up to
// the next zero byte are dropped. Four-byte leads and stray continuation bytes are dropped, and
// a non-zero byte that is not a continuation inside a sequence is swallowed together with that
// sequence. A byte is registered at the input and decoded from that register into a four-entry
// result queue; the block takes one byte per clock as long as the consumer takes one unit per
// clock. The input stalls only when the result queue holds more than two units, which needs
// m_tready low for a while; the extra unit of a forced termination does not stall a consumer
// that takes one unit per clock.
// max_chars lies at byte address 0 of the APB port and should be written while the block is idle.
module utf8_to_ucs2_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tlast,   // is_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import u8u2_pkg::*;

`include "utf8_to_ucs2_decoder_core_macros.svh"

  logic [15:0]       max_chars;
  logic              in_vld;
  logic [7:0]        in_byte;
  dec_state_t        st;
  dec_state_t        st_next;
  result_t           q [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] cnt;

  logic              proceed;
  logic              pop;
  logic [1:0]        n_res;
  result_t           res0;
  result_t           res1;
  logic [UNIT_W-1:0] cont_val;
  logic [15:0]       units_inc;
  logic              is_cont;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_CHARS) ? {16'd0, max_chars} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_MAX_CHARS) begin
      max_chars <= pwdata[15:0];
    end
  end

  // input register
  assign proceed  = in_vld && (cnt <= QCNT_W'(QDEPTH - 2));
  assign s_tready = !in_vld || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (proceed) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // decode
  assign is_cont   = (in_byte & CONT_MASK) == CONT_CODE;
  assign cont_val  = st.partial | {10'd0, in_byte[5:0]};
  assign units_inc = st.units + 16'd1;

  always_comb begin
    st_next = st;
    n_res   = 2'd0;
    res0    = '{unit: '0, last: 1'b0};
    res1    = '{unit: '0, last: 1'b1};
    if (st.skipping) begin
      if (in_byte == 8'd0) begin
        st_next = '0;
      end
    end else if (in_byte == 8'd0) begin
      st_next.pending = 2'd0;
      st_next.partial = '0;
      st_next.units   = '0;
      n_res           = 2'd1;
      res0            = '{unit: '0, last: 1'b1};
    end else if (st.pending != 2'd0) begin
      if (is_cont) begin
        if (st.pending == 2'd2) begin
          st_next.partial = st.partial | {4'd0, in_byte[5:0], 6'd0};
          st_next.pending = 2'd1;
        end else begin
          st_next.partial = cont_val;
          st_next.pending = 2'd0;
          n_res           = 2'd1;
          res0            = '{unit: cont_val, last: 1'b0};
        end
      end else begin
        st_next.pending = 2'd0;
        st_next.partial = '0;
      end
    end else if (in_byte[7] == 1'b0) begin
      n_res = 2'd1;
      res0  = '{unit: {8'd0, in_byte}, last: 1'b0};
    end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
      st_next.partial = {5'd0, in_byte[4:0], 6'd0};
      st_next.pending = 2'd1;
    end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
      st_next.partial = {in_byte[3:0], 12'd0};
      st_next.pending = 2'd2;
    end

    // unit count and forced termination
    if (n_res == 2'd1 && !res0.last) begin
      st_next.units = units_inc;
      if (units_inc >= max_chars) begin
        n_res            = 2'd2;
        st_next.pending  = 2'd0;
        st_next.partial  = '0;
        st_next.units    = '0;
        st_next.skipping = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (proceed) begin
      st <= st_next;
    end
  end

  // result queue
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = cnt != '0;
  assign m_tdata  = q[head].unit;
  assign m_tlast  = q[head].last;

  always_ff @(posedge clk) begin
    if (proceed && n_res != 2'd0) begin
      q[tail] <= res0;
      if (n_res == 2'd2) begin
        q[tail + QPTR_W'(1)] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
      if (proceed) begin
        tail <= tail + QPTR_W'(n_res);
      end
      cnt <= cnt + (proceed ? QCNT_W'(n_res) : '0) - (pop ? QCNT_W'(1) : '0);
    end
  end

  `U8U2_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= QCNT_W'(QDEPTH), "result queue overflow")
  `U8U2_ASSERT_NOW(a_last_zero, m_tvalid && m_tlast, m_tdata == 16'd0, "terminator not zero")
  `U8U2_ASSERT_NOW(a_skip_idle, st.skipping, st.pending == 2'd0 && st.units == 16'd0,
                   "sequence left open while skipping")
  `U8U2_ASSERT_NOW(a_pend_range, 1'b1, st.pending != 2'd3, "bad pending count")
  `U8U2_ASSERT_NEXT(a_force_end, proceed && n_res == 2'd2, st.skipping,
                    "forced termination without skip")

endmodule

/* tb/utf8_to_ucs2_decoder_core_test.sv */
module utf8_to_ucs2_decoder_core_test;
  import u8u2_pkg::*;

  localparam logic [2:0] MAX_CHARS_ADDR = 3'(4 * REG_MAX_CHARS);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [15:0] code_unit
  logic        m_tlast;        // is_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  result_t     expected_units[$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned units_checked = 0;
  int unsigned terminators_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // decoder state as predicted
  logic [15:0] limit_chars = MAX_CHARS_RST;
  logic [1:0]  cont_left = '0;
  logic [15:0] unit_acc = '0;
  logic [15:0] unit_count = '0;
  logic        dropping = 1'b0;

  utf8_to_ucs2_decoder_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_unit(input logic [15:0] u);
    expected_units.push_back('{unit: u, last: 1'b0});
    unit_count = unit_count + 16'd1;
    if (unit_count >= limit_chars) begin
      expected_units.push_back('{unit: '0, last: 1'b1});
      cont_left  = '0;
      unit_acc   = '0;
      unit_count = '0;
      dropping   = 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (dropping) begin
      if (b == 8'h00) begin
        dropping   = 1'b0;
        cont_left  = '0;
        unit_acc   = '0;
        unit_count = '0;
      end
    end else if (b == 8'h00) begin
      cont_left  = '0;
      unit_acc   = '0;
      unit_count = '0;
      expected_units.push_back('{unit: '0, last: 1'b1});
    end else if (cont_left != 2'd0) begin
      if ((b & CONT_MASK) == CONT_CODE) begin
        if (cont_left == 2'd2) begin
          unit_acc  = unit_acc | ({8'h00, b & CONT_BITS} << 6);
          cont_left = 2'd1;
        end else begin
          unit_acc  = unit_acc | {8'h00, b & CONT_BITS};
          cont_left = 2'd0;
          push_unit(unit_acc);
        end
      end else begin
        // broken sequence: byte swallowed along with it
        cont_left = 2'd0;
        unit_acc  = '0;
      end
    end else if (!b[7]) begin
      push_unit({8'h00, b});
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      unit_acc  = {8'h00, b & LEAD2_BITS} << 6;
      cont_left = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      unit_acc  = {8'h00, b & LEAD3_BITS} << 12;
      cont_left = 2'd2;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
  endtask

  // hold input until every expected unit is out, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_access(input bit do_write, input logic [15:0] value);
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MAX_CHARS_ADDR;
      pwdata  <= {16'h0000, value};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      limit_chars = value;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_CHARS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== limit_chars) begin
      $error("max_chars: expected %0d, actual %0d", limit_chars, prdata[15:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_units.size() == 0) begin
        $error("unexpected beat: code_unit %h is_last %b", m_tdata, m_tlast);
        errors++;
      end else begin
        want = expected_units.pop_front();
        units_checked++;
        if (m_tlast) terminators_seen++;
        if (m_tdata !== want.unit) begin
          $error("code_unit: expected %h, actual %h", want.unit, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("is_last: expected %b, actual %b", want.last, m_tlast);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_reset_value();
    reg_access(1'b0, '0);
  endtask

  task automatic test_sequence_forms();
    logic [7:0] seq[$];
    seq = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
            8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'hFF, 8'h80, 8'hBF, 8'hC3, 8'h41,
            8'hE2, 8'h82, 8'h00, 8'h41, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
    settle();
  endtask

  task automatic test_char_limit();
    reg_access(1'b1, 16'd1);
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(8'h43);
    send_byte(8'h00);
    settle();
    reg_access(1'b1, 16'd0);
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(8'h00);
    settle();
    reg_access(1'b1, 16'd3);
    send_byte(8'hC3);
    send_byte(8'hA9);
    send_byte(8'hE2);
    send_byte(8'h82);
    send_byte(8'hAC);
    send_byte(8'h7A);
    send_byte(8'h71);
    send_byte(8'h00);
    settle();
    // limit lowered below the count of a string already under way
    reg_access(1'b1, 16'hFFFF);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    settle();
    reg_access(1'b1, 16'd2);
    send_byte(8'h64);
    send_byte(8'h00);
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input logic [15:0] max_chars, input int unsigned n_bytes);
    int unsigned target;
    int unsigned kind;
    logic [7:0]  b;
    bit          drained;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    reg_access(1'b1, max_chars);
    target  = bytes_sent + n_bytes;
    drained = 1'b0;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        send_byte(8'($urandom_range(1, 127)));
      end else if (kind < 65) begin
        send_byte(8'hC0 | 8'($urandom_range(31)));
        send_byte(8'h80 | 8'($urandom_range(63)));
      end else if (kind < 80) begin
        send_byte(8'hE0 | 8'($urandom_range(15)));
        send_byte(8'h80 | 8'($urandom_range(63)));
        send_byte(8'h80 | 8'($urandom_range(63)));
      end else if (kind < 88) begin
        send_byte(8'h00);
      end else if (kind < 94) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        // lead then a byte that is not a continuation
        if ($urandom_range(1)) send_byte(8'hC0 | 8'($urandom_range(31)));
        else send_byte(8'hE0 | 8'($urandom_range(15)));
        if ($urandom_range(1)) send_byte(8'h80 | 8'($urandom_range(63)));
        b = 8'($urandom_range(255));
        if ((b & CONT_MASK) == CONT_CODE) b = b ^ 8'h40;
        send_byte(b);
      end
      if (!drained && bytes_sent >= target - n_bytes / 2) begin
        settle();
        drained = 1'b1;
      end
    end
    send_byte(8'h00);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_sequence_forms();
    test_char_limit();
    test_random_traffic(26, 53, 16'd5, 135);
    test_random_traffic(53, 26, 16'hFFFF, 135);
    test_random_traffic(0, 0, 16'($urandom_range(1, 40)), 135);
    $display("decoded %0d bytes into %0d checked units, %0d of them terminators",
             bytes_sent, units_checked, terminators_seen);
    $display("covered all sequence lengths, broken and dropped bytes, and forced termination");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
